/* src/tpr_pkg.sv */
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types and constants for the tachometer period and speed block.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int CLOCK_W   = 27;
  localparam int RELOAD_W  = 16;
  localparam int CAPTURE_W = 16;
  localparam int PERIOD_W  = 32;
  localparam int RPS_W     = 27;
  localparam int RPM_W     = 31;

  localparam logic [CLOCK_W-1:0]   CLOCK_HZ_RESET     = 27'd50000000;
  localparam logic [RELOAD_W-1:0]  TIMER_RELOAD_RESET = 16'hFFFF;
  localparam logic [CAPTURE_W-1:0] WRAP_MAX           = 16'hFFFF;

  // Register indexes on the configuration port
  localparam logic REG_CLOCK_HZ     = 1'b0;
  localparam logic REG_TIMER_RELOAD = 1'b1;

  // Shared divider: dividend width and step counts
  localparam int DIV_W    = 31;
  localparam int STEP_W   = 5;
  localparam int RPS_DVD_W = CLOCK_W - 2;
  localparam logic [STEP_W-1:0] RPS_STEPS = STEP_W'(RPS_DVD_W);
  localparam logic [STEP_W-1:0] RPM_STEPS = STEP_W'(DIV_W);

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [PERIOD_W-1:0] divisor;
    logic [STEP_W-1:0]   steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/tpr_cfg.sv */
// ----------------------------------------------------------------------------
// tpr_cfg
// Configuration registers behind a simple APB-style slave.
// ----------------------------------------------------------------------------
module tpr_cfg
  import tpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [CLOCK_W-1:0]  clock_hz,
  output logic [RELOAD_W-1:0] timer_reload
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz     <= CLOCK_HZ_RESET;
      timer_reload <= TIMER_RELOAD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_CLOCK_HZ:     clock_hz     <= pwdata[CLOCK_W-1:0];
        REG_TIMER_RELOAD: timer_reload <= pwdata[RELOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CLOCK_HZ:     prdata = {{(32-CLOCK_W){1'b0}}, clock_hz};
      REG_TIMER_RELOAD: prdata = {{(32-RELOAD_W){1'b0}}, timer_reload};
      default:          prdata = '0;
    endcase
  end

endmodule

/* src/tpr_div.sv */
// ----------------------------------------------------------------------------
// tpr_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by both rates.
// ----------------------------------------------------------------------------
module tpr_div
  import tpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   count;
  logic [PERIOD_W-1:0] rem;
  logic [DIV_W-1:0]    quo;
  logic [PERIOD_W-1:0] dsr;
  logic [PERIOD_W:0]   rem_shift;
  logic [PERIOD_W:0]   diff;
  logic                fits;

  assign rem_shift = {rem, quo[DIV_W-1]};
  assign diff      = rem_shift - {1'b0, dsr};
  assign fits      = ~diff[PERIOD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.steps;
        rem   <= '0;
        quo   <= req.dividend;
        dsr   <= req.divisor;
      end else if (busy) begin
        rem   <= fits ? diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
        quo   <= {quo[DIV_W-2:0], fits};
        count <= count - STEP_W'(1);
        if (count == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* src/tachometer_period_rpm.sv */
// ----------------------------------------------------------------------------
// tachometer_period_rpm
// Period and speed from capture-timer events of a down-counting timer.
//
//   channel  direction  handshake         contents
//   s_*      in         tvalid / tready   tdata: capture_value; tuser: flags
//   m_*      out        tvalid / tready   tdata: period, rev/s, rev/min
//   apb      in         psel / penable    clock_hz (0x0), timer_reload (0x4)
//
// An item passes from one input transfer to the next through wrap update,
// product, period, then two passes of the shared radix-2 divider (25 and 31
// steps, each with a start and a wait state) and an output load.
// With a zero period the divider is skipped.
// Reset is synchronous; no clearing pass follows it.
// A finished result waits in the output register while m_tready is low; the
// next item is taken meanwhile and holds in its last state until it drains.
// ----------------------------------------------------------------------------
module tachometer_period_rpm
  import tpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] capture_value
  input  logic [1:0]  s_tuser,   // [0] timeout_flag, [1] capture_flag
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] period_ticks, [58:32] revs_per_second,
                                 // [89:59] revs_per_minute, [95:90] zero
  output logic        m_tuser,   // [0] period_zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    IDLE,
    MUL,
    PER,
    RPS_START,
    RPS_WAIT,
    RPM_START,
    RPM_WAIT,
    DONE
  } state_t;

  state_t               state;
  logic                 capture_q;
  logic [CAPTURE_W-1:0] cap_q;
  logic [CAPTURE_W-1:0] wrap_count;
  logic [CAPTURE_W-1:0] last_capture;
  logic [PERIOD_W-1:0]  period_reg;
  logic [PERIOD_W-1:0]  extra;
  logic [RPS_W-1:0]     rps;
  logic [RPM_W-1:0]     rpm;

  logic [CLOCK_W-1:0]   clock_hz;
  logic [RELOAD_W-1:0]  timer_reload;
  logic [DIV_W-1:0]     clk15;
  logic [CAPTURE_W-1:0] wrap_next;
  logic                 in_xfer;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  tpr_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .clock_hz     (clock_hz),
    .timer_reload (timer_reload)
  );

  tpr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready  = (state == IDLE);
  assign in_xfer   = s_tvalid & s_tready;
  assign clk15     = {clock_hz, 4'b0} - {4'b0, clock_hz};
  assign wrap_next = (s_tuser[0] && wrap_count != WRAP_MAX) ?
                     wrap_count + CAPTURE_W'(1) : wrap_count;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {clock_hz[CLOCK_W-1:2], {(DIV_W-RPS_DVD_W){1'b0}}};
    div_req.divisor  = period_reg;
    div_req.steps    = RPS_STEPS;
    case (state)
      RPS_START: begin
        div_req.start = (period_reg != '0);
      end
      RPM_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = clk15;
        div_req.steps    = RPM_STEPS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      wrap_count   <= '0;
      last_capture <= '0;
      period_reg   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_xfer) begin
            capture_q  <= s_tuser[1];
            cap_q      <= s_tdata;
            wrap_count <= wrap_next;
            state      <= MUL;
          end
        end
        MUL: begin
          extra <= {16'b0, wrap_count} * {16'b0, timer_reload};
          state <= PER;
        end
        PER: begin
          if (capture_q) begin
            period_reg   <= {16'b0, last_capture} - {16'b0, cap_q} + extra;
            last_capture <= cap_q;
            wrap_count   <= '0;
          end
          state <= RPS_START;
        end
        RPS_START: begin
          rps <= '0;
          rpm <= '0;
          state <= (period_reg == '0) ? DONE : RPS_WAIT;
        end
        RPS_WAIT: begin
          if (div_rsp.done) begin
            rps   <= div_rsp.quotient[RPS_W-1:0];
            state <= RPM_START;
          end
        end
        RPM_START: begin
          state <= RPM_WAIT;
        end
        RPM_WAIT: begin
          if (div_rsp.done) begin
            rpm   <= div_rsp.quotient[RPM_W-1:0];
            state <= DONE;
          end
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, rpm, rps, period_reg};
            m_tuser  <= (period_reg == '0);
            state    <= IDLE;
          end else begin
            m_tvalid <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
